FILE: src/padf_pkg.sv
`default_nettype none
package padf_pkg;

  localparam int unsigned AXES = 3;

  // Working coordinate: wide enough for a signed 13-bit axis and the
  // unsigned 13-bit depth axis alike.
  typedef logic signed [13:0] coord_t;
  typedef coord_t [AXES-1:0] point_t;

  // Smoothed coordinate and raw-minus-smoothed error.
  typedef logic signed [14:0] smooth_t;
  typedef logic signed [15:0] err_t;

  typedef logic [7:0] width_t;
  typedef logic [1:0] cfg_idx_t;

  typedef enum logic [1:0] {
    REG_SMOOTH_X = 2'd0,
    REG_SMOOTH_Y = 2'd1,
    REG_SMOOTH_Z = 2'd2
  } cfg_reg_e;

  localparam width_t SMOOTH_RESET = 8'd5;

  // Bias that makes every history sum nonnegative before the mean divide.
  localparam int unsigned MEAN_OFFSET = 4096;

  // Virtual point divide by 500: exact reciprocal for magnitudes below 2**26.
  localparam int unsigned VIRT_DIVISOR = 500;
  localparam int unsigned VIRT_SHIFT   = 35;
  localparam longint unsigned VIRT_RECIP =
    ((64'd1 << VIRT_SHIFT) + 64'(VIRT_DIVISOR) - 64'd1) / 64'(VIRT_DIVISOR);

endpackage
`default_nettype wire

FILE: src/padf_hist_cell.sv
`default_nettype none
module padf_hist_cell (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire padf_pkg::point_t d_i,
  output padf_pkg::point_t      q_o
);
  import padf_pkg::*;

  point_t pt_q;

  // Hold one history point; advance it to the next cell on every transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q <= '0;
    end else if (en_i) begin
      pt_q <= d_i;
    end
  end

  assign q_o = pt_q;

endmodule
`default_nettype wire

FILE: src/padf_mean.sv
`default_nettype none
module padf_mean #(
  parameter int unsigned HISTORY_DEPTH = 8,
  localparam int unsigned SUM_W = 14 + $clog2(HISTORY_DEPTH)
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [SUM_W-1:0] sum_i,
  output padf_pkg::coord_t             avg_o
);
  import padf_pkg::*;

  localparam int unsigned LD    = $clog2(HISTORY_DEPTH);
  localparam int unsigned DIV_S = SUM_W + LD;
  localparam int unsigned MW    = SUM_W + 2;
  localparam int unsigned PW    = SUM_W + MW;
  localparam longint unsigned DIV_M =
    ((64'd1 << DIV_S) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);

  logic [SUM_W-1:0] biased;
  logic [PW-1:0]    prod;
  logic [13:0]      quot;
  coord_t           avg_q;

  // Bias the sum nonnegative, then divide by multiply-and-shift (exact floor).
  always_comb begin
    biased = SUM_W'(sum_i) + SUM_W'(HISTORY_DEPTH * MEAN_OFFSET);
    prod   = PW'(biased) * PW'(DIV_M);
    quot   = prod[DIV_S +: 14];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      avg_q <= coord_t'(quot - 14'(MEAN_OFFSET));
    end
  end

  assign avg_o = avg_q;

endmodule
`default_nettype wire

FILE: src/padf_band.sv
`default_nettype none
module padf_band (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire padf_pkg::coord_t avg_i,
  input  wire padf_pkg::coord_t raw_i,
  input  wire padf_pkg::width_t width_i,
  output padf_pkg::smooth_t     smooth_o
);
  import padf_pkg::*;

  smooth_t     sm_q, sm_d;
  err_t        err_q, err_d;
  logic [15:0] mag;
  logic        open_band;
  smooth_t     avg_ext, wid_ext;

  always_comb begin
    mag       = err_q[15] ? 16'(-err_q) : 16'(err_q);
    open_band = mag > {8'd0, width_i};
    avg_ext   = smooth_t'(avg_i);
    wid_ext   = $signed({7'd0, width_i});
    sm_d      = sm_q;
    if (open_band) begin
      // Pull back toward the mean by the width, against the last error.
      sm_d = err_q[15] ? (avg_ext + wid_ext) : (avg_ext - wid_ext);
    end
    err_d = err_t'(raw_i) - err_t'(sm_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_q  <= '0;
      err_q <= '0;
    end else if (en_i) begin
      sm_q  <= sm_d;
      err_q <= err_d;
    end
  end

  assign smooth_o = sm_q;

endmodule
`default_nettype wire

FILE: src/point_average_deadband_filter_unit.sv
// Each transaction passes registers S1 to S5 to reach out_valid_o. Throughput:
//   one transaction per cycle unless out_ready_i stalls; the running sums and the
//   deadband error loop through one register; the two multipliers are pipelined.
// Reset (rst_ni low, asynchronous): clear history cells, sums, smoothed point,
//   stored error and pipeline valids; set all smooth widths to 5.
`default_nettype none
module point_average_deadband_filter_unit #(
  parameter int unsigned HISTORY_DEPTH = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire padf_pkg::cfg_idx_t cfg_idx_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [12:0] raw_x_i,
  input  wire logic signed [12:0] raw_y_i,
  input  wire logic [12:0]        raw_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [12:0]      avg_x_o,
  output logic signed [12:0]      avg_y_o,
  output logic [12:0]             avg_z_o,
  output logic signed [13:0]      out_x_o,
  output logic signed [13:0]      out_y_o,
  output logic signed [14:0]      out_z_o,
  output logic signed [17:0]      virt_x_o,
  output logic signed [17:0]      virt_y_o
);
  import padf_pkg::*;

  localparam int unsigned SUM_W = 14 + $clog2(HISTORY_DEPTH);

  // ---------------------------------------------------------------------
  // Configuration: per-axis deadband half-widths. Unknown indexes drop.
  // ---------------------------------------------------------------------
  width_t wid_q [AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        wid_q[a] <= SMOOTH_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SMOOTH_X: wid_q[0] <= cfg_wdata_i;
        REG_SMOOTH_Y: wid_q[1] <= cfg_wdata_i;
        REG_SMOOTH_Z: wid_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake. Each stage advances when the next one is empty or
  // moving, so bubbles collapse and input keeps flowing into empty stages
  // while a finished result waits in the output register.
  //   S1: new sums + raw   S2: mean      S3: smoothed point
  //   S4: x*z, y*z         S5: output register
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic acc0, mv1, mv2, mv3, mv4;

  always_comb begin
    rdy5 = !v5_q || out_ready_i;
    rdy4 = !v4_q || rdy5;
    rdy3 = !v3_q || rdy4;
    rdy2 = !v2_q || rdy3;
    rdy1 = !v1_q || rdy2;
    acc0 = in_valid_i && rdy1;
    mv1  = v1_q && rdy2;
    mv2  = v2_q && rdy3;
    mv3  = v3_q && rdy4;
    mv4  = v4_q && rdy5;
  end

  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= acc0 || (v1_q && !mv1);
      v2_q <= mv1  || (v2_q && !mv2);
      v3_q <= mv2  || (v3_q && !mv3);
      v4_q <= mv3  || (v4_q && !mv4);
      v5_q <= mv4  || (v5_q && !out_ready_i);
    end
  end

  // ---------------------------------------------------------------------
  // History: a chain of cells, each holding one point. On every input
  // transaction the new point enters cell 0 and each point moves one cell
  // down; the last cell holds the point that leaves the window.
  // ---------------------------------------------------------------------
  point_t raw_pt;
  point_t hist_q [HISTORY_DEPTH];

  assign raw_pt = {{1'b0, raw_z_i}, {raw_y_i[12], raw_y_i}, {raw_x_i[12], raw_x_i}};

  for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_hist
    if (k == 0) begin : g_head
      padf_hist_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (acc0),
        .d_i    (raw_pt),
        .q_o    (hist_q[k])
      );
    end else begin : g_body
      padf_hist_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (acc0),
        .d_i    (hist_q[k-1]),
        .q_o    (hist_q[k])
      );
    end
  end

  // Running sums: add the arriving point, drop the departing one.
  logic signed [SUM_W-1:0] sum_q [AXES];
  logic signed [SUM_W-1:0] sum_d [AXES];
  logic signed [SUM_W-1:0] s1_sum_q [AXES];
  point_t                  s1_raw_q;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      sum_d[a] = sum_q[a] + SUM_W'($signed(raw_pt[a]))
               - SUM_W'($signed(hist_q[HISTORY_DEPTH-1][a]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        sum_q[a] <= '0;
      end
    end else if (acc0) begin
      for (int a = 0; a < AXES; a++) begin
        sum_q[a] <= sum_d[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc0) begin
      for (int a = 0; a < AXES; a++) begin
        s1_sum_q[a] <= sum_d[a];
      end
      s1_raw_q <= raw_pt;
    end
  end

  // ---------------------------------------------------------------------
  // S2: floored mean per axis (registered inside each mean unit).
  // ---------------------------------------------------------------------
  coord_t avg_w [AXES];
  point_t s2_raw_q;

  for (genvar a = 0; a < AXES; a++) begin : g_mean
    padf_mean #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_mean (
      .clk_i (clk_i),
      .en_i  (mv1),
      .sum_i (s1_sum_q[a]),
      .avg_o (avg_w[a])
    );
  end

  always_ff @(posedge clk_i) begin
    if (mv1) begin
      s2_raw_q <= s1_raw_q;
    end
  end

  // ---------------------------------------------------------------------
  // S3: deadband per axis. Each band cell's smoothed register is also the
  // S3 payload; it only changes when an item moves into S3.
  // ---------------------------------------------------------------------
  smooth_t sm_w [AXES];
  coord_t  s3_avg_q [AXES];

  for (genvar a = 0; a < AXES; a++) begin : g_band
    padf_band u_band (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (mv2),
      .avg_i    (avg_w[a]),
      .raw_i    ($signed(s2_raw_q[a])),
      .width_i  (wid_q[a]),
      .smooth_o (sm_w[a])
    );
  end

  always_ff @(posedge clk_i) begin
    if (mv2) begin
      for (int a = 0; a < AXES; a++) begin
        s3_avg_q[a] <= avg_w[a];
      end
    end
  end

  // ---------------------------------------------------------------------
  // S4: products for the virtual point.
  // ---------------------------------------------------------------------
  coord_t                s4_avg_q [AXES];
  smooth_t               s4_sm_q [AXES];
  logic signed [29:0]    s4_pxz_q, s4_pyz_q;

  always_ff @(posedge clk_i) begin
    if (mv3) begin
      for (int a = 0; a < AXES; a++) begin
        s4_avg_q[a] <= s3_avg_q[a];
        s4_sm_q[a]  <= sm_w[a];
      end
      s4_pxz_q <= 30'(sm_w[0]) * 30'(sm_w[2]);
      s4_pyz_q <= 30'(sm_w[1]) * 30'(sm_w[2]);
    end
  end

  // Divide by 500 truncating toward zero: work on the magnitude, then
  // restore the sign.
  function automatic logic signed [17:0] virt_div(input logic signed [29:0] p);
    logic [25:0] mag;
    logic [52:0] scaled;
    logic [16:0] quo;
    mag    = p[29] ? 26'(-p) : 26'(p);
    scaled = 53'(mag) * 53'(VIRT_RECIP);
    quo    = scaled[VIRT_SHIFT +: 17];
    return p[29] ? -$signed(18'(quo)) : $signed(18'(quo));
  endfunction

  // ---------------------------------------------------------------------
  // S5: output register.
  // ---------------------------------------------------------------------
  logic signed [12:0] avg_x_q, avg_y_q;
  logic [12:0]        avg_z_q;
  logic signed [13:0] out_x_q, out_y_q;
  logic signed [14:0] out_z_q;
  logic signed [17:0] virt_x_q, virt_y_q;

  always_ff @(posedge clk_i) begin
    if (mv4) begin
      avg_x_q  <= s4_avg_q[0][12:0];
      avg_y_q  <= s4_avg_q[1][12:0];
      avg_z_q  <= s4_avg_q[2][12:0];
      out_x_q  <= s4_sm_q[0][13:0];
      out_y_q  <= s4_sm_q[1][13:0];
      out_z_q  <= s4_sm_q[2];
      virt_x_q <= virt_div(s4_pxz_q);
      virt_y_q <= virt_div(s4_pyz_q);
    end
  end

  assign out_valid_o = v5_q;
  assign avg_x_o     = avg_x_q;
  assign avg_y_o     = avg_y_q;
  assign avg_z_o     = avg_z_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign virt_x_o    = virt_x_q;
  assign virt_y_o    = virt_y_q;

endmodule
`default_nettype wire
